FILE: hw/rtl/imuca_pkg.sv
`timescale 1ns / 1ps

package imuca_pkg;

    localparam int GYRO_W     = 16;
    localparam int ACC_W      = 16;
    localparam int MAG_W      = 16;
    localparam int OFF_W      = 23;
    localparam int WEIGHT_W   = 17;
    localparam int SCALE_W    = 16;
    localparam int OUT_W      = 25;
    localparam int STATE_W    = 40;
    localparam int RATE_W     = 17;
    localparam int THETA_W    = 34;
    localparam int WIDE_W     = 64;
    localparam int ANGLE_W    = 27;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // Shared signed multiplier of the filter sequencer.
    localparam int MA_W = 40;
    localparam int MB_W = 18;
    localparam int MP_W = 58;

    // Unsigned multiplier of the arcsine search.
    localparam int SQ_W   = 32;
    localparam int SP_W   = 64;
    localparam int F_W    = 31;
    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_RAD  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SQ   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DIV0 = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SINE = 4'd13;

    localparam int DIV_N     = 6;
    localparam int DIV_IDX_W = 3;
    localparam int DIV_K_W   = 8;

    localparam logic [DIV_K_W-1:0] DIV_K [0:DIV_N-1] = '{
        8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
    };

    // Reciprocals floor(2^32 / k) of the divisors above.
    localparam logic [SQ_W-1:0] DIV_RECIP [0:DIV_N-1] = '{
        32'd27531841, 32'd39045157, 32'd59652323,
        32'd102261126, 32'd214748364, 32'd715827882
    };

    localparam logic [SQ_W-1:0] DEG_TO_RAD_Q30 = 32'd18740330;
    localparam logic [F_W-1:0]  Q30_ONE        = 31'h4000_0000;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 17'd65536;
    localparam logic signed [WIDE_W-1:0] ROUND_16 = 64'sd32768;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef logic signed [STATE_W-1:0] t_state;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIAS_ROLL        = 3'd0,
        CFG_BIAS_PITCH       = 3'd1,
        CFG_BIAS_YAW         = 3'd2,
        CFG_ACC_OFFSET_PITCH = 3'd3,
        CFG_ACC_OFFSET_ROLL  = 3'd4,
        CFG_BLEND_WEIGHT     = 3'd5,
        CFG_INTEGRATION_SCALE = 3'd6,
        CFG_COUPLING_SCALE   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [GYRO_W-1:0] bias_roll;
        logic signed [GYRO_W-1:0] bias_pitch;
        logic signed [GYRO_W-1:0] bias_yaw;
        logic signed [OFF_W-1:0]  acc_offset_pitch;
        logic signed [OFF_W-1:0]  acc_offset_roll;
        logic [WEIGHT_W-1:0]      blend_weight;
        logic [SCALE_W-1:0]       integration_scale;
        logic [SCALE_W-1:0]       coupling_scale;
    } t_cfg;

    typedef struct packed {
        logic signed [GYRO_W-1:0] gyro_x;
        logic signed [GYRO_W-1:0] gyro_y;
        logic signed [GYRO_W-1:0] gyro_z;
        logic [MAG_W-1:0]         mag_x;
        logic                     neg_x;
        logic [MAG_W-1:0]         mag_y;
        logic                     neg_y;
        logic                     first;
    } t_item;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag;
    } t_asin_req;

    typedef struct packed {
        logic               done;
        logic [ANGLE_W-1:0] angle;
    } t_asin_rsp;

    typedef enum logic [1:0] {
        AS_IDLE,
        AS_MUL,
        AS_POST,
        AS_DONE
    } t_asin_state;

    typedef enum logic [4:0] {
        BK_IDLE,
        BK_THETA,
        BK_PIT,
        BK_ROL,
        BK_ROL2,
        BK_C1H,
        BK_C1L,
        BK_C1U,
        BK_C2H,
        BK_C2L,
        BK_C2U,
        BK_ASP_GO,
        BK_ASP_W,
        BK_ASR_GO,
        BK_ASR_W,
        BK_BP,
        BK_BR,
        BK_BR2,
        BK_OUT
    } t_back_state;

    function automatic t_state sat_state(input t_wide v, input t_wide lim);
        t_state res;
        if (v > lim) begin
            res = STATE_W'(lim);
        end else if (v < -lim) begin
            res = STATE_W'(-lim);
        end else begin
            res = STATE_W'(v);
        end
        return res;
    endfunction

    // Round half up of (hi * 2^16 + lo) / 2^32.
    function automatic t_wide round_q32(input logic signed [MP_W-1:0] hi,
                                        input logic signed [MP_W-1:0] lo);
        t_wide sum;
        sum = WIDE_W'(hi) + ROUND_16 + (WIDE_W'(lo) >>> 16);
        return sum >>> 16;
    endfunction

endpackage

FILE: hw/rtl/imuca_if.sv
`timescale 1ns / 1ps

interface imuca_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [imuca_pkg::GYRO_W-1:0]   gyro_x;
    logic signed [imuca_pkg::GYRO_W-1:0]   gyro_y;
    logic signed [imuca_pkg::GYRO_W-1:0]   gyro_z;
    logic signed [imuca_pkg::ACC_W-1:0]    acc_x;
    logic signed [imuca_pkg::ACC_W-1:0]    acc_y;

    modport source (output valid, gyro_x, gyro_y, gyro_z, acc_x, acc_y, input ready);
    modport sink (input valid, gyro_x, gyro_y, gyro_z, acc_x, acc_y, output ready);
endinterface

interface imuca_angle_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [imuca_pkg::OUT_W-1:0]   roll_deg;
    logic signed [imuca_pkg::OUT_W-1:0]   pitch_deg;

    modport source (output valid, roll_deg, pitch_deg, input ready);
    modport sink (input valid, roll_deg, pitch_deg, output ready);
endinterface

interface imuca_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [imuca_pkg::CFG_IDX_W-1:0]     index;
    logic [imuca_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/imuca_front.sv
`timescale 1ns / 1ps

module imuca_front #(
    parameter int ONE_G_COUNTS = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    imuca_sample_if.sink        i_sample,
    input  logic                i_full,
    output logic                o_push,
    output imuca_pkg::t_item    o_item
);

    localparam logic [imuca_pkg::ACC_W:0] ONE_G = (imuca_pkg::ACC_W + 1)'(ONE_G_COUNTS);

    logic r_seen;
    logic n_seen;
    logic [imuca_pkg::ACC_W:0] abs_x;
    logic [imuca_pkg::ACC_W:0] abs_y;

    always_comb begin
        abs_x = i_sample.acc_x[imuca_pkg::ACC_W-1]
              ? -{i_sample.acc_x[imuca_pkg::ACC_W-1], i_sample.acc_x}
              : {1'b0, i_sample.acc_x};
        abs_y = i_sample.acc_y[imuca_pkg::ACC_W-1]
              ? -{i_sample.acc_y[imuca_pkg::ACC_W-1], i_sample.acc_y}
              : {1'b0, i_sample.acc_y};

        o_item.gyro_x = i_sample.gyro_x;
        o_item.gyro_y = i_sample.gyro_y;
        o_item.gyro_z = i_sample.gyro_z;
        o_item.mag_x  = imuca_pkg::MAG_W'((abs_x > ONE_G) ? ONE_G : abs_x);
        o_item.neg_x  = i_sample.acc_x[imuca_pkg::ACC_W-1];
        o_item.mag_y  = imuca_pkg::MAG_W'((abs_y > ONE_G) ? ONE_G : abs_y);
        o_item.neg_y  = i_sample.acc_y[imuca_pkg::ACC_W-1];
        o_item.first  = !r_seen;

        i_sample.ready = !i_full;
        o_push = i_sample.valid && !i_full;
        n_seen = r_seen || o_push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= n_seen;
        end
    end

endmodule

FILE: hw/rtl/imuca_fifo.sv
`timescale 1ns / 1ps

module imuca_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  imuca_pkg::t_item    i_item,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output imuca_pkg::t_item    o_item
);

    imuca_pkg::t_item r_mem [imuca_pkg::Q_DEPTH];
    logic [imuca_pkg::Q_PTR_W-1:0] r_wr;
    logic [imuca_pkg::Q_PTR_W-1:0] r_rd;
    logic [imuca_pkg::Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == imuca_pkg::Q_CNT_W'(imuca_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + imuca_pkg::Q_CNT_W'(i_push) - imuca_pkg::Q_CNT_W'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue read while empty");

endmodule

FILE: hw/rtl/imuca_asin.sv
`timescale 1ns / 1ps

module imuca_asin #(
    parameter int ONE_G_COUNTS = 4096,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  imuca_pkg::t_asin_req    i_req,
    output imuca_pkg::t_asin_rsp    o_rsp
);

    localparam logic [imuca_pkg::ANGLE_W-1:0] ANG_FULL =
        imuca_pkg::ANGLE_W'(90 << OUT_FRAC_BITS);
    localparam logic [imuca_pkg::MAG_W-1:0] MAG_FULL = imuca_pkg::MAG_W'(ONE_G_COUNTS);
    localparam logic [imuca_pkg::SP_W-1:0] ONE_G_WIDE = imuca_pkg::SP_W'(ONE_G_COUNTS);

    imuca_pkg::t_asin_state r_state, n_state;
    logic [imuca_pkg::STEP_W-1:0]  r_step, n_step;
    logic [imuca_pkg::ANGLE_W-1:0] r_lo, n_lo;
    logic [imuca_pkg::ANGLE_W-1:0] r_hi, n_hi;
    logic [imuca_pkg::MAG_W-1:0]   r_mag, n_mag;
    logic [imuca_pkg::SP_W-1:0]    r_prod;
    logic [imuca_pkg::SQ_W-1:0]    r_r, n_r;
    logic [imuca_pkg::SQ_W-1:0]    r_r2, n_r2;
    logic [imuca_pkg::SQ_W-1:0]    r_x, n_x;
    logic [imuca_pkg::F_W-1:0]     r_f, n_f;

    logic [imuca_pkg::ANGLE_W:0]    span;
    logic [imuca_pkg::ANGLE_W-1:0]  mid;
    logic [imuca_pkg::SQ_W-1:0]     mul_a;
    logic [imuca_pkg::SQ_W-1:0]     mul_b;
    logic [imuca_pkg::DIV_IDX_W-1:0] div_idx;
    logic [imuca_pkg::SQ_W-1:0]     div_x;
    logic [imuca_pkg::DIV_K_W-1:0]  div_k;
    logic [imuca_pkg::SQ_W-1:0]     q0;
    logic [imuca_pkg::SQ_W:0]       rem;
    logic [imuca_pkg::SQ_W-1:0]     quot;
    logic [imuca_pkg::SQ_W-1:0]     sine;
    logic                           fits;

    always_comb begin
        span    = {1'b0, r_hi} - {1'b0, r_lo} + 1'b1;
        mid     = r_lo + imuca_pkg::ANGLE_W'(span >> 1);
        div_idx = r_step[imuca_pkg::STEP_W-1:1] - 3'd1;
        div_k   = imuca_pkg::DIV_K[div_idx];
        div_x   = (r_step == imuca_pkg::STEP_DIV0) ? r_r2 : r_x;

        priority if (r_step == imuca_pkg::STEP_RAD) begin
            mul_a = imuca_pkg::SQ_W'(mid);
            mul_b = imuca_pkg::DEG_TO_RAD_Q30;
        end else if (r_step == imuca_pkg::STEP_SQ) begin
            mul_a = r_r;
            mul_b = r_r;
        end else if (r_step == imuca_pkg::STEP_SINE) begin
            mul_a = r_r;
            mul_b = {1'b0, r_f};
        end else if (r_step[0]) begin
            mul_a = r_r2;
            mul_b = {1'b0, r_f};
        end else begin
            mul_a = div_x;
            mul_b = imuca_pkg::DIV_RECIP[div_idx];
        end

        q0   = r_prod[imuca_pkg::SP_W-1:imuca_pkg::SQ_W];
        rem  = {1'b0, div_x} - (imuca_pkg::SQ_W + 1)'(q0 * div_k);
        quot = (rem >= (imuca_pkg::SQ_W + 1)'(div_k)) ? q0 + 1'b1 : q0;
        sine = r_prod[30 +: imuca_pkg::SQ_W];
        fits = (imuca_pkg::SP_W'(sine) * ONE_G_WIDE) <= (imuca_pkg::SP_W'(r_mag) << 30);
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mag   = r_mag;
        n_r     = r_r;
        n_r2    = r_r2;
        n_x     = r_x;
        n_f     = r_f;
        o_rsp.done  = 1'b0;
        o_rsp.angle = r_lo;

        unique case (r_state)
            imuca_pkg::AS_IDLE: begin
                if (i_req.start) begin
                    n_mag  = i_req.mag;
                    n_step = imuca_pkg::STEP_RAD;
                    if (i_req.mag >= MAG_FULL) begin
                        n_lo    = ANG_FULL;
                        n_state = imuca_pkg::AS_DONE;
                    end else begin
                        n_lo    = '0;
                        n_hi    = ANG_FULL;
                        n_state = imuca_pkg::AS_MUL;
                    end
                end
            end
            imuca_pkg::AS_MUL: begin
                n_state = imuca_pkg::AS_POST;
            end
            imuca_pkg::AS_POST: begin
                n_step  = r_step + 1'b1;
                n_state = imuca_pkg::AS_MUL;
                priority if (r_step == imuca_pkg::STEP_RAD) begin
                    n_r = r_prod[OUT_FRAC_BITS +: imuca_pkg::SQ_W];
                end else if (r_step == imuca_pkg::STEP_SQ) begin
                    n_r2 = r_prod[30 +: imuca_pkg::SQ_W];
                end else if (r_step == imuca_pkg::STEP_SINE) begin
                    if (fits) begin
                        n_lo = mid;
                    end else begin
                        n_hi = mid - 1'b1;
                    end
                    n_step = imuca_pkg::STEP_RAD;
                    if (n_lo >= n_hi) begin
                        n_state = imuca_pkg::AS_DONE;
                    end
                end else if (r_step[0]) begin
                    n_x = r_prod[30 +: imuca_pkg::SQ_W];
                end else begin
                    n_f = imuca_pkg::Q30_ONE - imuca_pkg::F_W'(quot);
                end
            end
            imuca_pkg::AS_DONE: begin
                o_rsp.done = 1'b1;
                n_state    = imuca_pkg::AS_IDLE;
            end
            default: begin
                n_state = imuca_pkg::AS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imuca_pkg::AS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mag  <= n_mag;
        r_r    <= n_r;
        r_r2   <= n_r2;
        r_x    <= n_x;
        r_f    <= n_f;
        r_prod <= imuca_pkg::SP_W'(mul_a) * imuca_pkg::SP_W'(mul_b);
    end

endmodule

FILE: hw/rtl/imuca_back.sv
`timescale 1ns / 1ps

module imuca_back #(
    parameter int STATE_FRAC_BITS = 24,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  imuca_pkg::t_cfg         i_cfg,
    input  logic                    i_empty,
    input  imuca_pkg::t_item        i_item,
    output logic                    o_pop,
    output imuca_pkg::t_asin_req    o_asin_req,
    input  imuca_pkg::t_asin_rsp    i_asin_rsp,
    imuca_angle_if.source           o_angle
);

    localparam bit STATE_WIDER = (STATE_FRAC_BITS >= OUT_FRAC_BITS);
    localparam int GAP = STATE_WIDER ? (STATE_FRAC_BITS - OUT_FRAC_BITS)
                                     : (OUT_FRAC_BITS - STATE_FRAC_BITS);
    localparam imuca_pkg::t_wide LIM = 64'sd180 <<< STATE_FRAC_BITS;
    localparam imuca_pkg::t_wide HALF_GAP = (64'sd1 <<< GAP) >>> 1;

    imuca_pkg::t_back_state r_state, n_state;
    imuca_pkg::t_item r_item, n_item;
    imuca_pkg::t_state r_roll, n_roll;
    imuca_pkg::t_state r_pitch, n_pitch;
    imuca_pkg::t_state r_acc_p, n_acc_p;
    logic signed [imuca_pkg::THETA_W-1:0] r_theta, n_theta;
    logic signed [imuca_pkg::MP_W-1:0] r_mprod;
    logic signed [imuca_pkg::MP_W-1:0] r_hi, n_hi;
    logic r_out_valid, n_out_valid;
    logic signed [imuca_pkg::OUT_W-1:0] r_out_roll, n_out_roll;
    logic signed [imuca_pkg::OUT_W-1:0] r_out_pitch, n_out_pitch;

    logic signed [imuca_pkg::RATE_W-1:0] rate_roll;
    logic signed [imuca_pkg::RATE_W-1:0] rate_pitch;
    logic signed [imuca_pkg::RATE_W-1:0] rate_yaw;
    logic signed [imuca_pkg::MA_W-1:0] m_a;
    logic signed [imuca_pkg::MB_W-1:0] m_b;
    logic signed [imuca_pkg::MB_W-1:0] b_scale;
    logic signed [imuca_pkg::MB_W-1:0] b_weight;
    logic signed [imuca_pkg::MB_W-1:0] b_theta_hi;
    logic signed [imuca_pkg::MB_W-1:0] b_theta_lo;
    logic [imuca_pkg::WEIGHT_W-1:0] weight;
    logic load_out;
    imuca_pkg::t_state acc_now;
    imuca_pkg::t_wide acc_ang;
    imuca_pkg::t_wide acc_diff;
    imuca_pkg::t_wide acc_st;
    imuca_pkg::t_wide out_r;
    imuca_pkg::t_wide out_p;

    always_comb begin
        rate_roll  = imuca_pkg::RATE_W'(r_item.gyro_x) - imuca_pkg::RATE_W'(i_cfg.bias_roll);
        rate_pitch = imuca_pkg::RATE_W'(i_cfg.bias_pitch) - imuca_pkg::RATE_W'(r_item.gyro_y);
        rate_yaw   = imuca_pkg::RATE_W'(i_cfg.bias_yaw) - imuca_pkg::RATE_W'(r_item.gyro_z);
        weight     = (i_cfg.blend_weight > imuca_pkg::WEIGHT_MAX) ? imuca_pkg::WEIGHT_MAX
                                                                   : i_cfg.blend_weight;
        b_scale    = $signed({2'b00, i_cfg.integration_scale});
        b_weight   = $signed({1'b0, weight});
        b_theta_hi = r_theta[imuca_pkg::THETA_W-1:16];
        b_theta_lo = $signed({2'b00, r_theta[15:0]});

        unique case (r_state)
            imuca_pkg::BK_THETA: begin
                m_a = imuca_pkg::MA_W'(rate_yaw);
                m_b = $signed({2'b00, i_cfg.coupling_scale});
            end
            imuca_pkg::BK_PIT: begin
                m_a = imuca_pkg::MA_W'(rate_pitch);
                m_b = b_scale;
            end
            imuca_pkg::BK_ROL: begin
                m_a = imuca_pkg::MA_W'(rate_roll);
                m_b = b_scale;
            end
            imuca_pkg::BK_C1H: begin
                m_a = r_roll;
                m_b = b_theta_hi;
            end
            imuca_pkg::BK_C1L: begin
                m_a = r_roll;
                m_b = b_theta_lo;
            end
            imuca_pkg::BK_C2H: begin
                m_a = r_pitch;
                m_b = b_theta_hi;
            end
            imuca_pkg::BK_C2L: begin
                m_a = r_pitch;
                m_b = b_theta_lo;
            end
            imuca_pkg::BK_BP: begin
                m_a = r_acc_p - r_pitch;
                m_b = b_weight;
            end
            imuca_pkg::BK_BR: begin
                m_a = imuca_pkg::STATE_W'(r_hi) - r_roll;
                m_b = b_weight;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    always_comb begin
        if (r_state == imuca_pkg::BK_ASP_W) begin
            acc_ang  = imuca_pkg::WIDE_W'($signed({1'b0, i_asin_rsp.angle}));
            acc_ang  = r_item.neg_x ? -acc_ang : acc_ang;
            acc_diff = acc_ang - imuca_pkg::WIDE_W'($signed(i_cfg.acc_offset_pitch));
        end else begin
            acc_ang  = imuca_pkg::WIDE_W'($signed({1'b0, i_asin_rsp.angle}));
            acc_ang  = r_item.neg_y ? -acc_ang : acc_ang;
            acc_diff = acc_ang - imuca_pkg::WIDE_W'($signed(i_cfg.acc_offset_roll));
        end
        acc_st  = STATE_WIDER ? (acc_diff <<< GAP) : ((acc_diff + HALF_GAP) >>> GAP);
        acc_now = imuca_pkg::sat_state(acc_st, LIM);
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_roll      = r_roll;
        n_pitch     = r_pitch;
        n_acc_p     = r_acc_p;
        n_theta     = r_theta;
        n_hi        = r_hi;
        o_pop       = 1'b0;
        o_asin_req.start = 1'b0;
        o_asin_req.mag   = r_item.mag_x;
        load_out    = 1'b0;

        unique case (r_state)
            imuca_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_item  = i_item;
                    n_state = i_item.first ? imuca_pkg::BK_ASP_GO : imuca_pkg::BK_THETA;
                end
            end
            imuca_pkg::BK_THETA: begin
                n_state = imuca_pkg::BK_PIT;
            end
            imuca_pkg::BK_PIT: begin
                n_theta = r_mprod[imuca_pkg::THETA_W-1:0];
                n_state = imuca_pkg::BK_ROL;
            end
            imuca_pkg::BK_ROL: begin
                n_pitch = imuca_pkg::sat_state(imuca_pkg::WIDE_W'(r_pitch)
                                               + imuca_pkg::WIDE_W'(r_mprod), LIM);
                n_state = imuca_pkg::BK_ROL2;
            end
            imuca_pkg::BK_ROL2: begin
                n_roll  = imuca_pkg::sat_state(imuca_pkg::WIDE_W'(r_roll)
                                               + imuca_pkg::WIDE_W'(r_mprod), LIM);
                n_state = imuca_pkg::BK_C1H;
            end
            imuca_pkg::BK_C1H: begin
                n_state = imuca_pkg::BK_C1L;
            end
            imuca_pkg::BK_C1L: begin
                n_hi    = r_mprod;
                n_state = imuca_pkg::BK_C1U;
            end
            imuca_pkg::BK_C1U: begin
                n_pitch = imuca_pkg::sat_state(imuca_pkg::WIDE_W'(r_pitch)
                                               - imuca_pkg::round_q32(r_hi, r_mprod), LIM);
                n_state = imuca_pkg::BK_C2H;
            end
            imuca_pkg::BK_C2H: begin
                n_state = imuca_pkg::BK_C2L;
            end
            imuca_pkg::BK_C2L: begin
                n_hi    = r_mprod;
                n_state = imuca_pkg::BK_C2U;
            end
            imuca_pkg::BK_C2U: begin
                n_roll  = imuca_pkg::sat_state(imuca_pkg::WIDE_W'(r_roll)
                                               + imuca_pkg::round_q32(r_hi, r_mprod), LIM);
                n_state = imuca_pkg::BK_ASP_GO;
            end
            imuca_pkg::BK_ASP_GO: begin
                o_asin_req.start = 1'b1;
                o_asin_req.mag   = r_item.mag_x;
                n_state          = imuca_pkg::BK_ASP_W;
            end
            imuca_pkg::BK_ASP_W: begin
                if (i_asin_rsp.done) begin
                    n_acc_p = acc_now;
                    n_state = imuca_pkg::BK_ASR_GO;
                end
            end
            imuca_pkg::BK_ASR_GO: begin
                o_asin_req.start = 1'b1;
                o_asin_req.mag   = r_item.mag_y;
                n_state          = imuca_pkg::BK_ASR_W;
            end
            imuca_pkg::BK_ASR_W: begin
                if (i_asin_rsp.done) begin
                    // The roll accelerometer angle is held in r_hi until the blend.
                    n_hi = imuca_pkg::MP_W'(acc_now);
                    if (r_item.first) begin
                        n_pitch = r_acc_p;
                        n_roll  = acc_now;
                        n_state = imuca_pkg::BK_OUT;
                    end else begin
                        n_state = imuca_pkg::BK_BP;
                    end
                end
            end
            imuca_pkg::BK_BP: begin
                n_state = imuca_pkg::BK_BR;
            end
            imuca_pkg::BK_BR: begin
                n_pitch = imuca_pkg::sat_state(imuca_pkg::WIDE_W'(r_pitch)
                          + ((imuca_pkg::WIDE_W'(r_mprod) + imuca_pkg::ROUND_16) >>> 16), LIM);
                n_state = imuca_pkg::BK_BR2;
            end
            imuca_pkg::BK_BR2: begin
                n_roll  = imuca_pkg::sat_state(imuca_pkg::WIDE_W'(r_roll)
                          + ((imuca_pkg::WIDE_W'(r_mprod) + imuca_pkg::ROUND_16) >>> 16), LIM);
                n_state = imuca_pkg::BK_OUT;
            end
            imuca_pkg::BK_OUT: begin
                if (!r_out_valid || o_angle.ready) begin
                    load_out = 1'b1;
                    n_state  = imuca_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = imuca_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        out_r = STATE_WIDER ? ((imuca_pkg::WIDE_W'(r_roll) + HALF_GAP) >>> GAP)
                            : (imuca_pkg::WIDE_W'(r_roll) <<< GAP);
        out_p = STATE_WIDER ? ((imuca_pkg::WIDE_W'(r_pitch) + HALF_GAP) >>> GAP)
                            : (imuca_pkg::WIDE_W'(r_pitch) <<< GAP);
        n_out_valid = (r_out_valid && !o_angle.ready) || load_out;
        n_out_roll  = load_out ? out_r[imuca_pkg::OUT_W-1:0] : r_out_roll;
        n_out_pitch = load_out ? out_p[imuca_pkg::OUT_W-1:0] : r_out_pitch;
        o_angle.valid     = r_out_valid;
        o_angle.roll_deg  = r_out_roll;
        o_angle.pitch_deg = r_out_pitch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= imuca_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
            r_roll      <= '0;
            r_pitch     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_roll      <= n_roll;
            r_pitch     <= n_pitch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_acc_p     <= n_acc_p;
        r_theta     <= n_theta;
        r_hi        <= n_hi;
        r_mprod     <= imuca_pkg::MP_W'(m_a) * imuca_pkg::MP_W'(m_b);
        r_out_roll  <= n_out_roll;
        r_out_pitch <= n_out_pitch;
    end

    a_roll_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (imuca_pkg::WIDE_W'(r_roll) <= LIM) && (imuca_pkg::WIDE_W'(r_roll) >= -LIM))
        else $error("roll state beyond 180 degrees");

    a_pitch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (imuca_pkg::WIDE_W'(r_pitch) <= LIM) && (imuca_pkg::WIDE_W'(r_pitch) >= -LIM))
        else $error("pitch state beyond 180 degrees");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || o_angle.ready))
        else $error("output word overwritten before it was taken");

endmodule

FILE: hw/rtl/imu_complementary_attitude_core.sv
`timescale 1ns / 1ps

// Roll and pitch complementary filter for one IMU sample word per call. A front stage clamps the
// accelerometer counts and tags the first sample after reset, and a two-word queue feeds the
// back sequencer, so a new sample is taken while the previous one is still being worked on. The
// back sequencer does gyro integration and yaw coupling with one shared 40 by 18 bit multiplier,
// then runs two arcsine binary searches on a shared 32 by 32 bit multiplier, each search step
// being a polynomial sine evaluation. With the default 16 output fraction bits a search takes up
// to 23 steps; an accelerometer axis at or beyond one g skips its search. Configuration writes
// are taken every cycle and must be made while no sample is in flight.
module imu_complementary_attitude_core #(
    parameter int ONE_G_COUNTS = 4096,
    parameter int STATE_FRAC_BITS = 24,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    imuca_sample_if.sink    i_sample,
    imuca_cfg_if.sink       i_cfg,
    imuca_angle_if.source   o_angle
);

    imuca_pkg::t_cfg r_cfg;
    imuca_pkg::t_item push_item;
    imuca_pkg::t_item pop_item;
    imuca_pkg::t_asin_req asin_req;
    imuca_pkg::t_asin_rsp asin_rsp;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bias_roll         <= '0;
            r_cfg.bias_pitch        <= '0;
            r_cfg.bias_yaw          <= '0;
            r_cfg.acc_offset_pitch  <= 23'sd150733;
            r_cfg.acc_offset_roll   <= 23'sd58982;
            r_cfg.blend_weight      <= 17'd26;
            r_cfg.integration_scale <= 16'd1025;
            r_cfg.coupling_scale    <= 16'd4578;
        end else if (i_cfg.valid) begin
            unique case (imuca_pkg::t_cfg_idx'(i_cfg.index))
                imuca_pkg::CFG_BIAS_ROLL: r_cfg.bias_roll <= i_cfg.data[15:0];
                imuca_pkg::CFG_BIAS_PITCH: r_cfg.bias_pitch <= i_cfg.data[15:0];
                imuca_pkg::CFG_BIAS_YAW: r_cfg.bias_yaw <= i_cfg.data[15:0];
                imuca_pkg::CFG_ACC_OFFSET_PITCH: r_cfg.acc_offset_pitch <= i_cfg.data;
                imuca_pkg::CFG_ACC_OFFSET_ROLL: r_cfg.acc_offset_roll <= i_cfg.data;
                imuca_pkg::CFG_BLEND_WEIGHT: r_cfg.blend_weight <= i_cfg.data[16:0];
                imuca_pkg::CFG_INTEGRATION_SCALE: r_cfg.integration_scale <= i_cfg.data[15:0];
                imuca_pkg::CFG_COUPLING_SCALE: r_cfg.coupling_scale <= i_cfg.data[15:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    imuca_front #(
        .ONE_G_COUNTS (ONE_G_COUNTS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_full   (full),
        .o_push   (push),
        .o_item   (push_item)
    );

    imuca_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (pop_item)
    );

    imuca_asin #(
        .ONE_G_COUNTS  (ONE_G_COUNTS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_asin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (asin_req),
        .o_rsp   (asin_rsp)
    );

    imuca_back #(
        .STATE_FRAC_BITS (STATE_FRAC_BITS),
        .OUT_FRAC_BITS   (OUT_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (empty),
        .i_item     (pop_item),
        .o_pop      (pop),
        .o_asin_req (asin_req),
        .i_asin_rsp (asin_rsp),
        .o_angle    (o_angle)
    );

endmodule
